>>> src/dips_pkg.sv
// shared constants and types for the dual-wheel incremental pid speed block
package dips_pkg;

  localparam int MAX_DUTY_PCT = 30;
  localparam int ERR_LIMIT    = 50;

  localparam int GAIN_W   = 16;
  localparam int TARGET_W = 15;
  localparam int COUNT_W  = 16;
  localparam int SPEED_W  = COUNT_W + 1;
  localparam int DUTY_W   = 21;
  localparam int ERR_W    = 7;
  localparam int PROD_W   = 25;
  localparam int SUM_W    = 27;

  localparam logic [DUTY_W-1:0] DUTY_RESET = DUTY_W'(18 * 65536);
  localparam logic [DUTY_W-1:0] DUTY_MAX   = DUTY_W'(MAX_DUTY_PCT * 65536);

  localparam logic [2:0] REG_KP_LEFT      = 3'd0;
  localparam logic [2:0] REG_KI_LEFT      = 3'd1;
  localparam logic [2:0] REG_KD_LEFT      = 3'd2;
  localparam logic [2:0] REG_KP_RIGHT     = 3'd3;
  localparam logic [2:0] REG_KI_RIGHT     = 3'd4;
  localparam logic [2:0] REG_KD_RIGHT     = 3'd5;
  localparam logic [2:0] REG_TARGET_LEFT  = 3'd6;
  localparam logic [2:0] REG_TARGET_RIGHT = 3'd7;

  localparam logic [GAIN_W-1:0]   KP_LEFT_RESET  = 16'd328;
  localparam logic [GAIN_W-1:0]   KI_LEFT_RESET  = 16'd79;
  localparam logic [GAIN_W-1:0]   KD_LEFT_RESET  = 16'd164;
  localparam logic [GAIN_W-1:0]   KP_RIGHT_RESET = 16'd262;
  localparam logic [GAIN_W-1:0]   KI_RIGHT_RESET = 16'd98;
  localparam logic [GAIN_W-1:0]   KD_RIGHT_RESET = 16'd131;
  localparam logic [TARGET_W-1:0] TARGET_RESET   = 15'd150;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } stage_en_t;

endpackage

>>> src/dual_incremental_pid_speed_top.sv
// order: a word loads the error, then the gain products, then the output duty
// throughput: one word per cycle while out_stall is low; the duty accumulators close
// a loop in stage three and the error history a loop in stage two
// reset: synchronous; gains and targets take their defaults, error history
// clears and both duty accumulators restart at 18 percent
module dual_incremental_pid_speed_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [2:0]                           cfg_index,
  input  logic [dips_pkg::GAIN_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [dips_pkg::COUNT_W-1:0]  count_left,
  input  logic signed [dips_pkg::COUNT_W-1:0]  count_right,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dips_pkg::DUTY_W-1:0]          duty_left,
  output logic [dips_pkg::DUTY_W-1:0]          duty_right
);
  import dips_pkg::*;

  logic [GAIN_W-1:0]         kp_left;
  logic [GAIN_W-1:0]         ki_left;
  logic [GAIN_W-1:0]         kd_left;
  logic [GAIN_W-1:0]         kp_right;
  logic [GAIN_W-1:0]         ki_right;
  logic [GAIN_W-1:0]         kd_right;
  logic [TARGET_W-1:0]       target_left;
  logic [TARGET_W-1:0]       target_right;
  logic signed [SPEED_W-1:0] speed_left;
  logic signed [SPEED_W-1:0] speed_right;
  logic [DUTY_W-1:0]         lane_duty_left;
  logic [DUTY_W-1:0]         lane_duty_right;
  stage_en_t                 en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_left      <= KP_LEFT_RESET;
      ki_left      <= KI_LEFT_RESET;
      kd_left      <= KD_LEFT_RESET;
      kp_right     <= KP_RIGHT_RESET;
      ki_right     <= KI_RIGHT_RESET;
      kd_right     <= KD_RIGHT_RESET;
      target_left  <= TARGET_RESET;
      target_right <= TARGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KP_LEFT:      kp_left      <= cfg_data;
        REG_KI_LEFT:      ki_left      <= cfg_data;
        REG_KD_LEFT:      kd_left      <= cfg_data;
        REG_KP_RIGHT:     kp_right     <= cfg_data;
        REG_KI_RIGHT:     ki_right     <= cfg_data;
        REG_KD_RIGHT:     kd_right     <= cfg_data;
        REG_TARGET_LEFT:  target_left  <= cfg_data[TARGET_W-1:0];
        REG_TARGET_RIGHT: target_right <= cfg_data[TARGET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // left encoder runs reversed
  assign speed_left  = -SPEED_W'(count_left);
  assign speed_right = SPEED_W'(count_right);

  dips_lane u_lane_left (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .kp        (kp_left),
    .ki        (ki_left),
    .kd        (kd_left),
    .target    (target_left),
    .speed     (speed_left),
    .duty_next (lane_duty_left)
  );

  dips_lane u_lane_right (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .kp        (kp_right),
    .ki        (ki_right),
    .kd        (kd_right),
    .target    (target_right),
    .speed     (speed_right),
    .duty_next (lane_duty_right)
  );

  dips_merge u_merge (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .lane_duty_left  (lane_duty_left),
    .lane_duty_right (lane_duty_right),
    .duty_left       (duty_left),
    .duty_right      (duty_right),
    .en              (en)
  );

endmodule

>>> src/dips_lane.sv
// one wheel lane: error clamp, gain products, duty accumulate and clamp
module dips_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dips_pkg::stage_en_t                  en,
  input  logic [dips_pkg::GAIN_W-1:0]          kp,
  input  logic [dips_pkg::GAIN_W-1:0]          ki,
  input  logic [dips_pkg::GAIN_W-1:0]          kd,
  input  logic [dips_pkg::TARGET_W-1:0]        target,
  input  logic signed [dips_pkg::SPEED_W-1:0]  speed,
  output logic [dips_pkg::DUTY_W-1:0]          duty_next
);
  import dips_pkg::*;

  localparam int ERRW_W = SPEED_W + 1;

  logic signed [ERRW_W-1:0] err_raw;
  logic signed [ERR_W-1:0]  err_clamped;
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  last_err;
  logic signed [ERR_W-1:0]  prev_err;
  logic signed [ERR_W:0]    diff_p;
  logic signed [ERR_W+1:0]  diff_d;
  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [SUM_W-1:0]  duty_sum;
  logic [DUTY_W-1:0]        acc_duty;

  // stage 1: error and clamp
  always_comb begin
    err_raw = signed'(ERRW_W'({1'b0, target})) - ERRW_W'(speed);
    if (err_raw > ERRW_W'(ERR_LIMIT)) begin
      err_clamped = ERR_W'(ERR_LIMIT);
    end else if (err_raw < -ERRW_W'(ERR_LIMIT)) begin
      err_clamped = -ERR_W'(ERR_LIMIT);
    end else begin
      err_clamped = ERR_W'(err_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      err <= err_clamped;
    end
  end

  // stage 2: products against the error history
  always_comb begin
    diff_p = (ERR_W+1)'(err) - (ERR_W+1)'(last_err);
    diff_d = (ERR_W+2)'(err) - ((ERR_W+2)'(last_err) <<< 1) + (ERR_W+2)'(prev_err);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_err <= '0;
      prev_err <= '0;
    end else if (en.ld2) begin
      prev_err <= last_err;
      last_err <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      prod_p <= signed'(PROD_W'({1'b0, kp})) * PROD_W'(diff_p);
      prod_i <= signed'(PROD_W'({1'b0, ki})) * PROD_W'(err);
      prod_d <= signed'(PROD_W'({1'b0, kd})) * PROD_W'(diff_d);
    end
  end

  // stage 3: accumulate and clamp duty
  always_comb begin
    duty_sum = signed'(SUM_W'({1'b0, acc_duty})) + SUM_W'(prod_p) + SUM_W'(prod_i)
             + SUM_W'(prod_d);
    if (duty_sum < 0) begin
      duty_next = '0;
    end else if (duty_sum > signed'(SUM_W'({1'b0, DUTY_MAX}))) begin
      duty_next = DUTY_MAX;
    end else begin
      duty_next = DUTY_W'(duty_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_duty <= DUTY_RESET;
    end else if (en.ld3) begin
      acc_duty <= duty_next;
    end
  end

endmodule

>>> src/dips_merge.sv
// pipeline flow control and output register joining both lanes
module dips_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  logic [dips_pkg::DUTY_W-1:0]   lane_duty_left,
  input  logic [dips_pkg::DUTY_W-1:0]   lane_duty_right,
  output logic [dips_pkg::DUTY_W-1:0]   duty_left,
  output logic [dips_pkg::DUTY_W-1:0]   duty_right,
  output dips_pkg::stage_en_t           en
);
  import dips_pkg::*;

  logic v1;
  logic v2;
  logic out_adv;
  logic s1_free;
  logic s2_free;

  always_comb begin
    out_adv = !out_valid || !out_stall;
    en.ld3  = v2 && out_adv;
    s2_free = !v2 || en.ld3;
    en.ld2  = v1 && s2_free;
    s1_free = !v1 || en.ld2;
    en.ld1  = in_valid && s1_free;
    in_stall = !s1_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= en.ld1 || (v1 && !en.ld2);
      v2        <= en.ld2 || (v2 && !en.ld3);
      out_valid <= en.ld3 || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld3) begin
      duty_left  <= lane_duty_left;
      duty_right <= lane_duty_right;
    end
  end

endmodule
